@@ rtl/ttest_pkg.sv @@
`default_nettype none
package ttest_pkg;

  // field and register widths
  localparam int unsigned OP_W       = 3;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TEMPO_W    = 9;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TAPS_W     = 8;

  // divider widths
  localparam int unsigned DIV_NUM_W = 33;
  localparam int unsigned DIV_DEN_W = 32;

  localparam logic [MS_W-1:0] MS_PER_MIN = 16'd60000;

  // operation codes
  localparam logic [OP_W-1:0] OP_TAP     = 3'd0;
  localparam logic [OP_W-1:0] OP_UP      = 3'd1;
  localparam logic [OP_W-1:0] OP_DOWN    = 3'd2;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd4;

  // timer actions
  localparam logic [1:0] TMR_NONE   = 2'd0;
  localparam logic [1:0] TMR_ARM    = 2'd1;
  localparam logic [1:0] TMR_CANCEL = 2'd2;

  // metronome actions
  localparam logic [1:0] MET_NONE  = 2'd0;
  localparam logic [1:0] MET_START = 2'd1;
  localparam logic [1:0] MET_STOP  = 2'd2;
  localparam logic [1:0] MET_SET   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DLY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DLY_FLOOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DLY_CEIL  = 3'd6;

  // register reset values
  localparam logic [MS_W-1:0]    RST_DEBOUNCE  = 16'd120;
  localparam logic [MS_W-1:0]    RST_WINDOW    = 16'd5000;
  localparam logic [TEMPO_W-1:0] RST_TEMPO_MIN = 9'd30;
  localparam logic [TEMPO_W-1:0] RST_TEMPO_MAX = 9'd300;
  localparam logic [MS_W-1:0]    RST_FIRST_DLY = 16'd2000;
  localparam logic [MS_W-1:0]    RST_DLY_FLOOR = 16'd400;
  localparam logic [MS_W-1:0]    RST_DLY_CEIL  = 16'd5000;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic front;
    logic walk_init;
    logic walk;
    logic est_start;
    logic est_apply;
    logic sched;
    logic dly_start;
    logic dly_apply;
    logic emit;
  } ttest_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic tap_stored;
    logic sched_req;
    logic walk_done;
    logic est_ok;
    logic sched_div;
    logic div_done;
    logic out_busy;
  } ttest_sts_t;

endpackage
`default_nettype wire

@@ rtl/ttest_if.sv @@
`default_nettype none
interface ttest_in_if;
  logic                         valid;
  logic                         ready;
  logic [ttest_pkg::OP_W-1:0]   operation;
  logic [ttest_pkg::TIME_W-1:0] now_ms;
  logic                         metronome_running;
  modport source (output valid, output operation, output now_ms,
                  output metronome_running, input ready);
  modport sink (input valid, input operation, input now_ms,
                input metronome_running, output ready);
endinterface

interface ttest_out_if;
  logic                          valid;
  logic                          ready;
  logic [ttest_pkg::TEMPO_W-1:0] tempo;
  logic                          tap_accepted;
  logic [1:0]                    timer_action;
  logic [ttest_pkg::MS_W-1:0]    timer_delay_ms;
  logic [1:0]                    metronome_action;
  logic [ttest_pkg::TIME_W-1:0]  phase_anchor_ms;
  modport source (output valid, output tempo, output tap_accepted,
                  output timer_action, output timer_delay_ms,
                  output metronome_action, output phase_anchor_ms, input ready);
  modport sink (input valid, input tempo, input tap_accepted,
                input timer_action, input timer_delay_ms,
                input metronome_action, input phase_anchor_ms, output ready);
endinterface

interface ttest_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ttest_pkg::CFG_IDX_W-1:0]  index;
  logic [ttest_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/tap_tempo_estimator.sv @@
`default_nettype none
// Tap tempo estimator: takes one event per transfer (tap, tempo up, tempo
// down, timeout fired, stop) and returns exactly one result transfer with
// the tempo, a timer request and a metronome request. Items are handled one
// at a time. A tempo change that reschedules runs a 33-step divide; one that
// only arms or cancels runs none. A stored tap walks the timestamp ring
// newest first, one entry a cycle, then runs up to two divides on one shared
// radix-2 divider. A stalled result receiver holds back the next result.
// The next item is taken while the previous result waits in the output
// register. Configuration writes are taken every cycle; write only while
// idle. Ring entries are valid only up to the fill count; no clearing pass.
module tap_tempo_estimator #(
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ttest_in_if.sink    in_ch,
  ttest_out_if.source out_ch,
  ttest_cfg_if.sink   cfg_ch
);

  ttest_pkg::ttest_cmd_t cmd;
  ttest_pkg::ttest_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  ttest_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttest_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_operation         (in_ch.operation),
    .in_now_ms            (in_ch.now_ms),
    .in_metronome_running (in_ch.metronome_running),
    .cfg_wr               (cfg_ch.valid),
    .cfg_idx              (cfg_ch.index),
    .cfg_data             (cfg_ch.data),
    .out_ready            (out_ch.ready),
    .out_valid            (out_ch.valid),
    .out_tempo            (out_ch.tempo),
    .out_tap_accepted     (out_ch.tap_accepted),
    .out_timer_action     (out_ch.timer_action),
    .out_timer_delay_ms   (out_ch.timer_delay_ms),
    .out_metronome_action (out_ch.metronome_action),
    .out_phase_anchor_ms  (out_ch.phase_anchor_ms)
  );

endmodule
`default_nettype wire

@@ rtl/ttest_div.sv @@
`default_nettype none
module ttest_div (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic [ttest_pkg::DIV_NUM_W-1:0]     num,
  input  wire logic [ttest_pkg::DIV_DEN_W-1:0]     den,
  output logic                                     done,
  output logic [ttest_pkg::DIV_NUM_W-1:0]          quo
);

  localparam int unsigned NW = ttest_pkg::DIV_NUM_W;
  localparam int unsigned DW = ttest_pkg::DIV_DEN_W;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r;
  logic [NW-1:0] num_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, num_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so it always fits in DW bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      num_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DW-1:0] : trial[DW-1:0];
      num_r <= {num_r[NW-2:0], 1'b0};
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

@@ rtl/ttest_ctrl.sv @@
`default_nettype none
module ttest_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire ttest_pkg::ttest_sts_t sts,
  output ttest_pkg::ttest_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_FRONT, S_WINIT, S_WALK, S_EST, S_EDIV, S_EAPP,
    S_SCHED, S_DDIV, S_DAPP, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // sequencing of one item
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_FRONT;
      end
      S_FRONT: begin
        cmd.front = 1'b1;
        if (sts.tap_stored)     state_nxt = S_WINIT;
        else if (sts.sched_req) state_nxt = S_SCHED;
        else                    state_nxt = S_FIN;
      end
      S_WINIT: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) state_nxt = S_EST;
      end
      S_EST: begin
        cmd.est_start = sts.est_ok;
        state_nxt     = sts.est_ok ? S_EDIV : S_SCHED;
      end
      S_EDIV: begin
        if (sts.div_done) state_nxt = S_EAPP;
      end
      S_EAPP: begin
        cmd.est_apply = 1'b1;
        state_nxt     = S_SCHED;
      end
      S_SCHED: begin
        cmd.sched     = 1'b1;
        cmd.dly_start = sts.sched_div;
        state_nxt     = sts.sched_div ? S_DDIV : S_FIN;
      end
      S_DDIV: begin
        if (sts.div_done) state_nxt = S_DAPP;
      end
      S_DAPP: begin
        cmd.dly_apply = 1'b1;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        cmd.emit = !sts.out_busy;
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

endmodule
`default_nettype wire

@@ rtl/ttest_dp.sv @@
`default_nettype none
module ttest_dp #(
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire ttest_pkg::ttest_cmd_t                 cmd,
  output ttest_pkg::ttest_sts_t                      sts,
  input  wire logic [ttest_pkg::OP_W-1:0]            in_operation,
  input  wire logic [ttest_pkg::TIME_W-1:0]          in_now_ms,
  input  wire logic                                  in_metronome_running,
  input  wire logic                                  cfg_wr,
  input  wire logic [ttest_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [ttest_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                  out_ready,
  output logic                                       out_valid,
  output logic [ttest_pkg::TEMPO_W-1:0]              out_tempo,
  output logic                                       out_tap_accepted,
  output logic [1:0]                                 out_timer_action,
  output logic [ttest_pkg::MS_W-1:0]                 out_timer_delay_ms,
  output logic [1:0]                                 out_metronome_action,
  output logic [ttest_pkg::TIME_W-1:0]               out_phase_anchor_ms
);

  localparam int unsigned IW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned TW  = ttest_pkg::TIME_W;
  localparam int unsigned PW  = ttest_pkg::TEMPO_W;
  localparam int unsigned MW  = ttest_pkg::MS_W;
  localparam int unsigned NW  = ttest_pkg::DIV_NUM_W;
  localparam int unsigned DW  = ttest_pkg::DIV_DEN_W;
  localparam int unsigned AW  = ttest_pkg::TAPS_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(HISTORY_DEPTH - 1);
  localparam logic [CW-1:0] FULL     = CW'(HISTORY_DEPTH);

  // configuration registers
  logic [MW-1:0] debounce_r, window_r, first_dly_r, dly_floor_r, dly_ceil_r;
  logic [PW-1:0] tmin_r, tmax_r;

  // captured item
  logic [ttest_pkg::OP_W-1:0] op_r;
  logic [TW-1:0]              now_r;
  logic                       run_r;

  // tracker state
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [TW-1:0] last_r, last_nxt;
  logic          last_vld_r, last_vld_nxt;
  logic [TW-1:0] anchor_r, anchor_nxt;
  logic [AW-1:0] taps_r, taps_nxt;
  logic [PW-1:0] tempo_r, tempo_nxt;

  // result under construction
  logic          res_acc_r, res_acc_nxt;
  logic [1:0]    res_tmr_r, res_tmr_nxt;
  logic [MW-1:0] res_dly_r, res_dly_nxt;
  logic [1:0]    res_met_r, res_met_nxt;
  logic [TW-1:0] res_phase_r, res_phase_nxt;

  // output register
  logic          out_valid_r;
  logic [PW-1:0] out_tempo_r;
  logic          out_acc_r;
  logic [1:0]    out_tmr_r;
  logic [MW-1:0] out_dly_r;
  logic [1:0]    out_met_r;
  logic [TW-1:0] out_phase_r;

  // timestamp ring and window walk
  logic [TW-1:0] ring_mem [HISTORY_DEPTH];
  logic [TW-1:0] rdata_r;
  logic [IW-1:0] rd_idx_r;
  logic [CW-1:0] issued_r;
  logic          pend_r;
  logic          stop_r;
  logic [CW-1:0] cnt_r;
  logic [TW-1:0] oldest_r, newest_r;

  logic          tap_store;
  logic [IW-1:0] wr_idx;
  logic          tempo_ok;
  logic [PW:0]   bump;
  logic [PW-1:0] bump_base;
  logic [TW-1:0] total;
  logic [NW-1:0] est_num;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_done;
  logic [NW-1:0] div_quo;
  logic [NW-1:0] est_q;
  logic [PW-1:0] est_val;
  logic [MW:0]   dly_val;
  logic          issue;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= ttest_pkg::RST_DEBOUNCE;
      window_r    <= ttest_pkg::RST_WINDOW;
      tmin_r      <= ttest_pkg::RST_TEMPO_MIN;
      tmax_r      <= ttest_pkg::RST_TEMPO_MAX;
      first_dly_r <= ttest_pkg::RST_FIRST_DLY;
      dly_floor_r <= ttest_pkg::RST_DLY_FLOOR;
      dly_ceil_r  <= ttest_pkg::RST_DLY_CEIL;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ttest_pkg::CFG_DEBOUNCE:  debounce_r  <= cfg_data;
        ttest_pkg::CFG_WINDOW:    window_r    <= cfg_data;
        ttest_pkg::CFG_TEMPO_MIN: tmin_r      <= cfg_data[PW-1:0];
        ttest_pkg::CFG_TEMPO_MAX: tmax_r      <= cfg_data[PW-1:0];
        ttest_pkg::CFG_FIRST_DLY: first_dly_r <= cfg_data;
        ttest_pkg::CFG_DLY_FLOOR: dly_floor_r <= cfg_data;
        ttest_pkg::CFG_DLY_CEIL:  dly_ceil_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_operation;
      now_r <= in_now_ms;
      run_r <= in_metronome_running;
    end
  end

  assign tempo_ok = (tempo_r != '0) && (tempo_r >= tmin_r) && (tempo_r <= tmax_r);

  // tempo nudge, clamped to the limits
  always_comb begin
    bump_base = (tempo_r < tmin_r) ? tmin_r : tempo_r;
    if (op_r == ttest_pkg::OP_UP)  bump = {1'b0, bump_base} + 1'b1;
    else if (bump_base == '0)      bump = {1'b0, tmin_r};
    else                           bump = {1'b0, bump_base} - 1'b1;
    if (bump < {1'b0, tmin_r}) bump = {1'b0, tmin_r};
    if (bump > {1'b0, tmax_r}) bump = {1'b0, tmax_r};
  end

  // per-operation update of state and result
  always_comb begin
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    last_nxt      = last_r;
    last_vld_nxt  = last_vld_r;
    anchor_nxt    = anchor_r;
    taps_nxt      = taps_r;
    tempo_nxt     = tempo_r;
    res_acc_nxt   = 1'b0;
    res_tmr_nxt   = ttest_pkg::TMR_NONE;
    res_dly_nxt   = '0;
    res_met_nxt   = ttest_pkg::MET_NONE;
    res_phase_nxt = '0;
    tap_store     = 1'b0;
    wr_idx        = head_r;
    case (op_r)
      ttest_pkg::OP_TAP: begin
        if (run_r) begin
          taps_nxt     = '0;
          fill_nxt     = '0;
          head_nxt     = '0;
          last_nxt     = '0;
          last_vld_nxt = 1'b0;
          anchor_nxt   = '0;
          res_met_nxt  = ttest_pkg::MET_STOP;
          res_tmr_nxt  = ttest_pkg::TMR_CANCEL;
        end
        tap_store = !(last_vld_nxt && ((now_r - last_nxt) < TW'(debounce_r)));
        wr_idx    = head_nxt;
        if (tap_store) begin
          head_nxt     = (head_nxt == LAST_IDX) ? '0 : head_nxt + 1'b1;
          if (fill_nxt != FULL) fill_nxt = fill_nxt + 1'b1;
          last_nxt     = now_r;
          last_vld_nxt = 1'b1;
          anchor_nxt   = now_r;
          if (taps_nxt != '1) taps_nxt = taps_nxt + 1'b1;
          res_acc_nxt  = 1'b1;
        end
      end
      ttest_pkg::OP_UP, ttest_pkg::OP_DOWN: begin
        tempo_nxt  = bump[PW-1:0];
        anchor_nxt = now_r;
        if (run_r) begin
          res_met_nxt   = ttest_pkg::MET_SET;
          res_phase_nxt = now_r;
        end
      end
      ttest_pkg::OP_TIMEOUT: begin
        if (!run_r && tempo_ok && (taps_r >= AW'(2)) && (fill_r >= CW'(2))) begin
          res_met_nxt   = ttest_pkg::MET_START;
          res_phase_nxt = anchor_r;
          taps_nxt      = '0;
          fill_nxt      = '0;
          head_nxt      = '0;
          last_nxt      = '0;
          last_vld_nxt  = 1'b0;
        end
      end
      ttest_pkg::OP_STOP: begin
        if (run_r) begin
          taps_nxt     = '0;
          fill_nxt     = '0;
          head_nxt     = '0;
          last_nxt     = '0;
          last_vld_nxt = 1'b0;
          anchor_nxt   = '0;
          res_met_nxt  = ttest_pkg::MET_STOP;
          res_tmr_nxt  = ttest_pkg::TMR_CANCEL;
        end
      end
      default: ;
    endcase
  end

  // estimate numerator and clamping
  assign total   = newest_r - oldest_r;
  assign est_num = NW'(ttest_pkg::MS_PER_MIN) * NW'(cnt_r - 1'b1) + NW'(total >> 1);
  assign div_num = cmd.est_start ? est_num : NW'(ttest_pkg::MS_PER_MIN);
  assign div_den = cmd.est_start ? total : DW'(tempo_r);

  always_comb begin
    est_q = div_quo;
    if (est_q < NW'(tmin_r)) est_q = NW'(tmin_r);
    if (est_q > NW'(tmax_r)) est_q = NW'(tmax_r);
    est_val = est_q[PW-1:0];
    dly_val = {div_quo[MW-1:0], 1'b0};
    if (dly_val < {1'b0, dly_floor_r}) dly_val = {1'b0, dly_floor_r};
    if (dly_val > {1'b0, dly_ceil_r})  dly_val = {1'b0, dly_ceil_r};
  end

  // tracker and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      fill_r     <= '0;
      last_r     <= '0;
      last_vld_r <= 1'b0;
      anchor_r   <= '0;
      taps_r     <= '0;
      tempo_r    <= '0;
    end else if (cmd.front) begin
      head_r     <= head_nxt;
      fill_r     <= fill_nxt;
      last_r     <= last_nxt;
      last_vld_r <= last_vld_nxt;
      anchor_r   <= anchor_nxt;
      taps_r     <= taps_nxt;
      tempo_r    <= tempo_nxt;
    end else if (cmd.est_apply) begin
      if ((est_val != '0) && (est_val >= tmin_r)) tempo_r <= est_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.front) begin
      res_acc_r   <= res_acc_nxt;
      res_tmr_r   <= res_tmr_nxt;
      res_dly_r   <= res_dly_nxt;
      res_met_r   <= res_met_nxt;
      res_phase_r <= res_phase_nxt;
    end else if (cmd.sched && !sts.sched_div) begin
      if (fill_r < CW'(2)) begin
        res_tmr_r <= ttest_pkg::TMR_ARM;
        res_dly_r <= first_dly_r;
      end else begin
        res_tmr_r <= ttest_pkg::TMR_CANCEL;
        res_dly_r <= '0;
      end
    end else if (cmd.dly_apply) begin
      res_tmr_r <= ttest_pkg::TMR_ARM;
      res_dly_r <= dly_val[MW-1:0];
    end
  end

  // ring write on a stored tap, walk reads newest first
  assign issue = cmd.walk && !stop_r && (issued_r != fill_r);

  always_ff @(posedge clk) begin
    if (cmd.front && tap_store) ring_mem[wr_idx] <= now_r;
    if (issue) rdata_r <= ring_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b0;
      stop_r   <= 1'b0;
      issued_r <= '0;
      cnt_r    <= '0;
    end else if (cmd.walk_init) begin
      rd_idx_r <= (head_r == '0) ? LAST_IDX : head_r - 1'b1;
      issued_r <= '0;
      pend_r   <= 1'b0;
      stop_r   <= 1'b0;
      cnt_r    <= '0;
    end else if (cmd.walk) begin
      pend_r <= issue;
      if (issue) begin
        rd_idx_r <= (rd_idx_r == '0) ? LAST_IDX : rd_idx_r - 1'b1;
        issued_r <= issued_r + 1'b1;
      end
      if (pend_r && !stop_r) begin
        if ((now_r - rdata_r) > TW'(window_r)) begin
          stop_r <= 1'b1;
        end else begin
          cnt_r    <= cnt_r + 1'b1;
          oldest_r <= rdata_r;
          if (cnt_r == '0) newest_r <= rdata_r;
        end
      end
    end
  end

  ttest_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.est_start || cmd.dly_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tempo_r <= tempo_r;
      out_acc_r   <= res_acc_r;
      out_tmr_r   <= res_tmr_r;
      out_dly_r   <= res_dly_r;
      out_met_r   <= res_met_r;
      out_phase_r <= res_phase_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_tempo            = out_tempo_r;
  assign out_tap_accepted     = out_acc_r;
  assign out_timer_action     = out_tmr_r;
  assign out_timer_delay_ms   = out_dly_r;
  assign out_metronome_action = out_met_r;
  assign out_phase_anchor_ms  = out_phase_r;

  // status to the controller
  assign sts.tap_stored = (op_r == ttest_pkg::OP_TAP) && tap_store;
  assign sts.sched_req  = ((op_r == ttest_pkg::OP_UP) || (op_r == ttest_pkg::OP_DOWN))
                          && !run_r && (taps_r != '0);
  assign sts.walk_done  = stop_r || ((issued_r == fill_r) && !pend_r);
  assign sts.est_ok     = (cnt_r >= CW'(2)) && (total != '0);
  assign sts.sched_div  = (fill_r >= CW'(2)) && tempo_ok;
  assign sts.div_done   = div_done;
  assign sts.out_busy   = out_valid_r && !out_ready;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("ring fill beyond depth");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.est_start || cmd.dly_start) |-> (div_den != '0))
    else $error("divide by zero started");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted result not presented");

endmodule
`default_nettype wire
